[rtl/pdc_pkg.sv]
package pdc_pkg;

	localparam int unsigned ObjW = 32;
	localparam int unsigned IdxW = 6;

	typedef struct packed {
		logic signed [ObjW-1:0] first_obj;
		logic signed [ObjW-1:0] second_obj;
	} point_t;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_QUERY  = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic load_ref;
		logic cmp_en;
	} scan_ctl_t;

endpackage

[rtl/pdc_point_mem.sv]
module pdc_point_mem
	import pdc_pkg::*;
#(
	parameter int unsigned Depth = 64,
	parameter int unsigned AddrW = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  point_t           wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output point_t           rd_data
);

	point_t mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/pdc_scan.sv]
module pdc_scan
	import pdc_pkg::*;
(
	input  logic      clk,
	input  scan_ctl_t ctl,
	input  point_t    rd_data,
	output logic      dom_now
);

	point_t ref_q;
	logic   sticky_q;
	logic   ge_first;
	logic   ge_second;
	logic   same;
	logic   hit;

	// candidate dominates reference: >= in both, not equal in both
	assign ge_first  = rd_data.first_obj >= ref_q.first_obj;
	assign ge_second = rd_data.second_obj >= ref_q.second_obj;
	assign same      = (rd_data.first_obj == ref_q.first_obj) &&
	                   (rd_data.second_obj == ref_q.second_obj);
	assign hit       = ctl.cmp_en && ge_first && ge_second && !same;
	assign dom_now   = sticky_q || hit;

	always_ff @(posedge clk) begin
		if (ctl.load_ref) begin
			ref_q    <= rd_data;
			sticky_q <= 1'b0;
		end else if (hit) begin
			sticky_q <= 1'b1;
		end
	end

endmodule

[rtl/pareto_dominance_check.sv]
// Table of up to MAX_POINTS two-objective points (signed Q16.16, larger is
// better) in one synchronous memory. Append, clear, unused modes and
// out-of-range queries are handled without a scan: busy stays low and the result word
// shows on done in the next cycle. An in-range query reads the queried point,
// then streams every stored point through one comparator, one memory read per
// cycle: busy is high through the load and the scan, and the result word shows on
// done in the same cycle that busy drops. done is a one-cycle strobe; results are
// not held, so the receiver must take them when they appear.
module pareto_dominance_check
	import pdc_pkg::*;
#(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             mode,
	input  logic signed [ObjW-1:0] first_objective,
	input  logic signed [ObjW-1:0] second_objective,
	input  logic [IdxW-1:0]        query_index,
	output logic                   done,
	output logic                   dominated,
	output logic [IdxW-1:0]        point_index,
	output logic [1:0]             status
);

	localparam int unsigned AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
	localparam int unsigned CMPW = (CW > IdxW) ? CW : IdxW;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   scan_q;
	logic [AW-1:0]   scan_s1;
	logic [AW-1:0]   qry_q;
	logic            done_q;
	logic            dominated_q;
	logic [IdxW-1:0] point_index_q;
	status_t         status_q;

	logic            accept;
	logic            full;
	logic            in_range;
	logic            more;
	logic            wr_en;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	point_t          wr_data;
	point_t          rd_data;
	scan_ctl_t       scan_ctl;
	logic            dom_now;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q >= CW'(MAX_POINTS));
	assign in_range = (CMPW'(query_index) < CMPW'(count_q));
	assign more     = (scan_q < count_q);

	assign wr_data.first_obj  = first_objective;
	assign wr_data.second_obj = second_objective;

	always_comb begin
		state_d         = state_q;
		wr_en           = 1'b0;
		rd_en           = 1'b0;
		rd_addr         = scan_q[AW-1:0];
		scan_ctl        = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = AW'(query_index);
				if (accept && mode == MODE_APPEND && !full) begin
					wr_en = 1'b1;
				end
				if (accept && mode == MODE_QUERY && in_range) begin
					rd_en   = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				scan_ctl.load_ref = 1'b1;
				rd_en             = 1'b1;
				state_d           = ST_SCAN;
			end
			ST_SCAN: begin
				scan_ctl.cmp_en = (scan_s1 != qry_q);
				rd_en           = more;
				if (!more) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (accept) begin
				case (mode)
					MODE_APPEND: begin
						if (!full) count_q <= count_q + 1'b1;
						done_q <= 1'b1;
					end
					MODE_QUERY: done_q <= !in_range;
					MODE_CLEAR: begin
						count_q <= '0;
						done_q  <= 1'b1;
					end
					default: done_q <= 1'b1;
				endcase
			end
			if (state_q == ST_SCAN && !more) begin
				done_q <= 1'b1;
			end
		end
	end

	// scan pointers and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			dominated_q   <= 1'b0;
			point_index_q <= '0;
			status_q      <= STAT_OK;
			qry_q         <= AW'(query_index);
			scan_q        <= '0;
			case (mode)
				MODE_APPEND: begin
					if (full) status_q <= STAT_FULL;
					else point_index_q <= IdxW'(count_q);
				end
				MODE_QUERY: begin
					point_index_q <= query_index;
					if (!in_range) status_q <= STAT_RANGE;
				end
				default: ;
			endcase
		end
		if (rd_en && state_q != ST_IDLE) begin
			scan_s1 <= scan_q[AW-1:0];
			scan_q  <= scan_q + 1'b1;
		end
		if (state_q == ST_SCAN && !more) begin
			dominated_q <= dom_now;
		end
	end

	pdc_point_mem #(
		.Depth (MAX_POINTS),
		.AddrW (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pdc_scan u_scan (
		.clk     (clk),
		.ctl     (scan_ctl),
		.rd_data (rd_data),
		.dom_now (dom_now)
	);

	assign done        = done_q;
	assign dominated   = dominated_q;
	assign point_index = point_index_q;
	assign status      = status_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count above table depth");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> count_q != '0)
		else $error("scan with empty table");

	a_load_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> state_q == ST_SCAN)
		else $error("load not followed by scan");

	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q != STAT_OK |-> !dominated)
		else $error("dominated flag set on error word");
`endif

endmodule

[tb/pareto_dominance_check_tb.sv]
module pareto_dominance_check_tb
	import pdc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned TARGET_WORDS = 1200;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic signed [ObjW-1:0] OBJ_MIN = 32'sh8000_0000;
	localparam logic signed [ObjW-1:0] OBJ_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [1:0]             mode;
		logic signed [ObjW-1:0] first_obj;
		logic signed [ObjW-1:0] second_obj;
		logic [IdxW-1:0]        index;
		int unsigned            gap;
		bit                     drain;
	} command_word_t;

	typedef struct packed {
		logic            dominated;
		logic [IdxW-1:0] point_index;
		status_t         status;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [1:0]             mode = MODE_CLEAR;
	logic signed [ObjW-1:0] first_objective = '0;
	logic signed [ObjW-1:0] second_objective = '0;
	logic [IdxW-1:0]        query_index = '0;
	logic                   done;
	logic                   dominated;
	logic [IdxW-1:0]        point_index;
	logic [1:0]             status;

	pareto_dominance_check #(.MAX_POINTS(TABLE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.first_objective(first_objective),
		.second_objective(second_objective),
		.query_index(query_index),
		.done(done),
		.dominated(dominated),
		.point_index(point_index),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [ObjW-1:0] stored_first [TABLE_DEPTH];
	logic signed [ObjW-1:0] stored_second [TABLE_DEPTH];
	int unsigned            stored_count = 0;

	command_word_t pending_words [$];
	verdict_t      awaited_verdicts [$];
	command_word_t staged_word;
	command_word_t live_word;
	bit            have_staged = 1'b0;
	int unsigned   idle_left = 0;
	int unsigned   total_words = 0;
	int unsigned   accepted_words = 0;
	int unsigned   mismatch_count = 0;
	int unsigned   cycle_count = 0;

	// generator side
	int unsigned   shadow_count = 0;
	bit            no_idle = 1'b0;

	int unsigned   n_append = 0, n_full = 0, n_dominated = 0, n_front = 0;
	int unsigned   n_range = 0, n_clear = 0, n_unused = 0;

	function automatic verdict_t predict_verdict(command_word_t w);
		verdict_t v;
		v.dominated = 1'b0;
		v.point_index = '0;
		v.status = STAT_OK;
		case (w.mode)
			MODE_APPEND: begin
				if (stored_count >= TABLE_DEPTH) begin
					v.status = STAT_FULL;
					n_full++;
				end else begin
					stored_first[stored_count] = w.first_obj;
					stored_second[stored_count] = w.second_obj;
					v.point_index = stored_count[IdxW-1:0];
					stored_count++;
					n_append++;
				end
			end
			MODE_QUERY: begin
				v.point_index = w.index;
				if (w.index >= stored_count) begin
					v.status = STAT_RANGE;
					n_range++;
				end else begin
					for (int unsigned j = 0; j < stored_count; j++) begin
						if (j != w.index &&
						    stored_first[j] >= stored_first[w.index] &&
						    stored_second[j] >= stored_second[w.index] &&
						    (stored_first[j] > stored_first[w.index] ||
						     stored_second[j] > stored_second[w.index]))
							v.dominated = 1'b1;
					end
					if (v.dominated)
						n_dominated++;
					else
						n_front++;
				end
			end
			MODE_CLEAR: begin
				stored_count = 0;
				n_clear++;
			end
			default: n_unused++;
		endcase
		return v;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// clustered values so that ties and near-ties are common
	function automatic logic signed [ObjW-1:0] pick_objective();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return ($signed(ObjW'($urandom_range(0, 6))) - 3) <<< 16;
		else if (r < 50)
			return $signed(ObjW'($urandom_range(0, 6))) - 3;
		else if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return OBJ_MIN;
				1: return OBJ_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic push_word(logic [1:0] m, logic signed [ObjW-1:0] f,
	                         logic signed [ObjW-1:0] s, logic [IdxW-1:0] q,
	                         bit drain = 1'b0);
		command_word_t w;
		w.mode = m;
		w.first_obj = f;
		w.second_obj = s;
		w.index = q;
		w.gap = pick_gap();
		w.drain = drain;
		pending_words.push_back(w);
		if (m == MODE_APPEND && shadow_count < TABLE_DEPTH)
			shadow_count++;
		else if (m == MODE_CLEAR)
			shadow_count = 0;
		if (m != MODE_UNUSED)
			total_words++;
	endtask

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	// driver: a word is taken at an edge where start is high and busy is low
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited_verdicts.push_back(predict_verdict(live_word));
				accepted_words++;
			end
			if (!start || !busy) begin
				if (!have_staged && pending_words.size() > 0) begin
					staged_word = pending_words.pop_front();
					have_staged = 1'b1;
					idle_left = staged_word.gap;
				end
				if (have_staged && idle_left == 0 &&
				    !(staged_word.drain && awaited_verdicts.size() != 0)) begin
					live_word = staged_word;
					have_staged = 1'b0;
					start <= 1'b1;
					mode <= staged_word.mode;
					first_objective <= staged_word.first_obj;
					second_objective <= staged_word.second_obj;
					query_index <= staged_word.index;
				end else begin
					if (idle_left > 0)
						idle_left--;
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: done is a one-cycle strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected word dom=%0b idx=%0d status=%0d",
					dominated, point_index, status));
			end else begin
				verdict_t exp_v;
				exp_v = awaited_verdicts.pop_front();
				if (dominated !== exp_v.dominated || point_index !== exp_v.point_index ||
				    status !== exp_v.status)
					report_mismatch($sformatf(
						"expected dom=%0b idx=%0d status=%0d, got dom=%0b idx=%0d status=%0d",
						exp_v.dominated, exp_v.point_index, exp_v.status,
						dominated, point_index, status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d words taken", cycle_count,
				accepted_words, total_words);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned n_points;
		int unsigned n_queries;
		bit          first_pass;

		// directed: empty table, extremes, ties, single point
		push_word(MODE_QUERY, '0, '0, 6'd0);
		push_word(MODE_QUERY, '0, '0, 6'd63);
		push_word(MODE_CLEAR, '0, '0, '0);
		push_word(MODE_UNUSED, OBJ_MAX, OBJ_MIN, 6'd17);
		push_word(MODE_APPEND, OBJ_MIN, OBJ_MIN, '0);
		push_word(MODE_APPEND, OBJ_MAX, OBJ_MAX, '0);
		push_word(MODE_APPEND, OBJ_MAX, OBJ_MIN, '0);
		push_word(MODE_APPEND, OBJ_MIN, OBJ_MAX, '0);
		push_word(MODE_APPEND, OBJ_MAX, OBJ_MAX, '0);
		for (int i = 0; i < 6; i++)
			push_word(MODE_QUERY, '0, '0, IdxW'(i));
		push_word(MODE_CLEAR, '0, '0, '0, 1'b1);
		push_word(MODE_QUERY, '0, '0, 6'd0);
		push_word(MODE_APPEND, 32'sh0000_0000, 32'sh0000_0000, '0);
		push_word(MODE_APPEND, 32'sh0000_0000, 32'sh0000_0001, '0);
		push_word(MODE_APPEND, -32'sh0001_0000, 32'sh0000_0001, '0);
		push_word(MODE_QUERY, '0, '0, 6'd0);
		push_word(MODE_QUERY, '0, '0, 6'd1);
		push_word(MODE_QUERY, '0, '0, 6'd2);
		push_word(MODE_CLEAR, '0, '0, '0);
		push_word(MODE_APPEND, -32'sd1, 32'sh0001_0000, '0);
		push_word(MODE_QUERY, '0, '0, 6'd0);

		// random: fill a table, then query it; the first pass overfills
		first_pass = 1'b1;
		while (total_words < TARGET_WORDS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if (first_pass || $urandom_range(0, 3) != 0)
				push_word(MODE_CLEAR, $urandom, $urandom, IdxW'($urandom), first_pass);
			if (first_pass)
				n_points = TABLE_DEPTH + 3;
			else if ($urandom_range(0, 9) == 0)
				n_points = $urandom_range(40, 70);
			else
				n_points = $urandom_range(1, 12);
			for (int unsigned i = 0; i < n_points; i++) begin
				if ($urandom_range(0, 99) < 3)
					push_word(MODE_UNUSED, $urandom, $urandom, IdxW'($urandom));
				push_word(MODE_APPEND, pick_objective(), pick_objective(),
					IdxW'($urandom), $urandom_range(0, 99) == 0);
			end
			n_queries = $urandom_range(1, 16);
			for (int unsigned i = 0; i < n_queries; i++) begin
				if (shadow_count > 0 && $urandom_range(0, 99) < 85)
					push_word(MODE_QUERY, $urandom, $urandom,
						IdxW'($urandom_range(0, shadow_count - 1)));
				else
					push_word(MODE_QUERY, $urandom, $urandom, IdxW'($urandom));
			end
			first_pass = 1'b0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted_words == pending_words.size() + accepted_words &&
		      !have_staged && !(start === 1'b1));
		wait (awaited_verdicts.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (awaited_verdicts.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_verdicts.size()));
		$display("covered %0d appends, %0d full drops, %0d clears, %0d unused-mode words",
			n_append, n_full, n_clear, n_unused);
		$display("queries: %0d dominated, %0d on the front, %0d out of range; %0d mismatches",
			n_dominated, n_front, n_range, mismatch_count);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
